>>> rtl/core/itr_pkg.sv
// itr_pkg: types, constants and table functions for the roman numeral encoder
// used by itr_ctrl, itr_datapath and integer_to_roman_encoder; no dependencies
`timescale 1ns / 1ps

package itr_pkg;

    localparam int VALUE_W  = 12;
    localparam int SYMBOL_W = 7;
    localparam int CAND_W   = 14;
    localparam int MAX_VALUE = 3999;

    // ascii codes of the numeral characters
    localparam logic [SYMBOL_W-1:0] CH_I = 7'h49;
    localparam logic [SYMBOL_W-1:0] CH_V = 7'h56;
    localparam logic [SYMBOL_W-1:0] CH_X = 7'h58;
    localparam logic [SYMBOL_W-1:0] CH_L = 7'h4C;
    localparam logic [SYMBOL_W-1:0] CH_C = 7'h43;
    localparam logic [SYMBOL_W-1:0] CH_D = 7'h44;
    localparam logic [SYMBOL_W-1:0] CH_M = 7'h4D;
    localparam logic [SYMBOL_W-1:0] CH_NONE = 7'h00;

    // decimal positions
    localparam logic [1:0] POS_UNITS     = 2'd0;
    localparam logic [1:0] POS_TENS      = 2'd1;
    localparam logic [1:0] POS_HUNDREDS  = 2'd2;
    localparam logic [1:0] POS_THOUSANDS = 2'd3;

    typedef enum logic [1:0] {
        SEL_ONE,
        SEL_FIVE,
        SEL_TEN
    } t_sel;

    typedef struct packed {
        logic load;
        logic emit_bad;
        logic digit;
        logic emit;
        logic next_pos;
    } t_cmd;

    typedef struct packed {
        logic in_bad;
        logic out_free;
        logic dig_nonzero;
        logic dig_single;
        logic rem_next_zero;
        logic pat_end;
        logic rem_zero;
    } t_status;

    // number of characters in the pattern of one decimal digit
    function automatic logic [2:0] pat_len(input logic [3:0] d);
        logic [2:0] len;
        case (d) inside
            4'd1, 4'd5:       len = 3'd1;
            4'd2, 4'd4, 4'd6, 4'd9: len = 3'd2;
            4'd3, 4'd7:       len = 3'd3;
            4'd8:             len = 3'd4;
            default:          len = 3'd0;
        endcase
        return len;
    endfunction

    // which symbol of the position stands at character idx of the pattern
    function automatic t_sel pat_sel(input logic [3:0] d, input logic [1:0] idx);
        t_sel s;
        case (d) inside
            [4'd1:4'd3]: s = SEL_ONE;
            4'd4:        s = (idx == 2'd0) ? SEL_ONE : SEL_FIVE;
            4'd5:        s = SEL_FIVE;
            [4'd6:4'd8]: s = (idx == 2'd0) ? SEL_FIVE : SEL_ONE;
            4'd9:        s = (idx == 2'd0) ? SEL_ONE : SEL_TEN;
            default:     s = SEL_ONE;
        endcase
        return s;
    endfunction

    function automatic logic [SYMBOL_W-1:0] pos_symbol(input logic [1:0] pos, input t_sel s);
        logic [SYMBOL_W-1:0] ch;
        case (pos)
            POS_UNITS:    ch = (s == SEL_ONE) ? CH_I : ((s == SEL_FIVE) ? CH_V : CH_X);
            POS_TENS:     ch = (s == SEL_ONE) ? CH_X : ((s == SEL_FIVE) ? CH_L : CH_C);
            POS_HUNDREDS: ch = (s == SEL_ONE) ? CH_C : ((s == SEL_FIVE) ? CH_D : CH_M);
            default:      ch = CH_M;
        endcase
        return ch;
    endfunction

    // k times the weight of a position; k is always an elaboration constant
    function automatic logic [CAND_W-1:0] pos_mult(input logic [1:0] pos, input int k);
        logic [CAND_W-1:0] m;
        case (pos)
            POS_UNITS:    m = CAND_W'(k);
            POS_TENS:     m = CAND_W'(k * 10);
            POS_HUNDREDS: m = CAND_W'(k * 100);
            default:      m = CAND_W'(k * 1000);
        endcase
        return m;
    endfunction

endpackage

>>> rtl/core/itr_ctrl.sv
// itr_ctrl: sequencing state machine of the roman numeral encoder
// depends on itr_pkg for the command and status structs
`timescale 1ns / 1ps

module itr_ctrl
    import itr_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  t_status i_status,
    output t_cmd    o_cmd,
    output logic    o_stall
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_BAD,
        ST_DIGIT,
        ST_EMIT
    } t_state;

    t_state r_state, n_state;
    logic   r_stall;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state = i_status.in_bad ? ST_BAD : ST_DIGIT;
                end
            end
            ST_BAD: begin
                if (i_status.out_free) begin
                    o_cmd.emit_bad = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            ST_DIGIT: begin
                if (i_status.out_free) begin
                    o_cmd.digit = 1'b1;
                    if (i_status.dig_nonzero && !i_status.dig_single) begin
                        n_state = ST_EMIT;
                    end else if (i_status.rem_next_zero) begin
                        n_state = ST_IDLE;
                    end else begin
                        o_cmd.next_pos = 1'b1;
                    end
                end
            end
            ST_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_status.pat_end) begin
                        if (i_status.rem_zero) begin
                            n_state = ST_IDLE;
                        end else begin
                            o_cmd.next_pos = 1'b1;
                            n_state = ST_DIGIT;
                        end
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_stall <= 1'b0;
        end else begin
            r_state <= n_state;
            r_stall <= (n_state != ST_IDLE);
        end
    end

    assign o_stall = r_stall;

endmodule

>>> rtl/core/itr_datapath.sv
// itr_datapath: remainder, digit and pattern registers plus the output register
// depends on itr_pkg for tables, command and status structs
`timescale 1ns / 1ps

module itr_datapath
    import itr_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [VALUE_W-1:0]  i_value,
    input  logic                i_stall,
    input  t_cmd                i_cmd,
    output t_status             o_status,
    output logic                o_valid,
    output logic [SYMBOL_W-1:0] o_symbol,
    output logic                o_last,
    output logic                o_invalid
);

    logic [VALUE_W-1:0]  r_rem;
    logic [1:0]          r_pos;
    logic [3:0]          r_digit;
    logic [1:0]          r_idx;
    logic                r_valid;
    logic [SYMBOL_W-1:0] r_symbol;
    logic                r_last;
    logic                r_invalid;

    logic [CAND_W-1:0]   cand [10];
    logic [3:0]          dig;
    logic [VALUE_W-1:0]  rem_next;
    logic [2:0]          dig_len;
    logic [2:0]          cur_len;
    logic [SYMBOL_W-1:0] first_ch;
    logic [SYMBOL_W-1:0] emit_ch;

    // digit of the current position by parallel compares against its multiples
    always_comb begin
        dig = 4'd0;
        for (int k = 0; k < 10; k++) begin
            cand[k] = pos_mult(r_pos, k);
        end
        for (int k = 1; k < 10; k++) begin
            if ({{(CAND_W-VALUE_W){1'b0}}, r_rem} >= cand[k]) begin
                dig = 4'(k);
            end
        end
    end

    assign rem_next = r_rem - cand[dig][VALUE_W-1:0];
    assign dig_len  = pat_len(dig);
    assign cur_len  = pat_len(r_digit);
    assign first_ch = pos_symbol(r_pos, pat_sel(dig, 2'd0));
    assign emit_ch  = pos_symbol(r_pos, pat_sel(r_digit, r_idx));

    always_comb begin
        o_status.in_bad        = (i_value == '0) || (i_value > VALUE_W'(MAX_VALUE));
        o_status.out_free      = !r_valid || !i_stall;
        o_status.dig_nonzero   = (dig != 4'd0);
        o_status.dig_single    = (dig_len == 3'd1);
        o_status.rem_next_zero = (rem_next == '0);
        o_status.pat_end       = ({1'b0, r_idx} == (cur_len - 3'd1));
        o_status.rem_zero      = (r_rem == '0);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_rem <= i_value;
            r_pos <= POS_THOUSANDS;
        end
        if (i_cmd.digit) begin
            r_digit <= dig;
            r_rem   <= rem_next;
            r_idx   <= 2'd1;
        end
        if (i_cmd.emit) begin
            r_idx <= r_idx + 2'd1;
        end
        if (i_cmd.next_pos) begin
            r_pos <= r_pos - 2'd1;
        end
    end

    // output register, one character at a time
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_cmd.emit_bad || i_cmd.emit || (i_cmd.digit && dig != 4'd0)) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_bad) begin
            r_symbol  <= CH_NONE;
            r_last    <= 1'b1;
            r_invalid <= 1'b1;
        end else if (i_cmd.digit && dig != 4'd0) begin
            r_symbol  <= first_ch;
            r_last    <= (dig_len == 3'd1) && (rem_next == '0);
            r_invalid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_symbol  <= emit_ch;
            r_last    <= o_status.pat_end && (r_rem == '0);
            r_invalid <= 1'b0;
        end
    end

    assign o_valid   = r_valid;
    assign o_symbol  = r_symbol;
    assign o_last    = r_last;
    assign o_invalid = r_invalid;

endmodule

>>> rtl/core/integer_to_roman_encoder.sv
// integer_to_roman_encoder: one request in, its roman numeral out one character per cycle while
//   the output does not stall and no zero digit is being skipped; a request is loaded in the idle
//   state, then each digit state skips a zero digit or loads a character into the output register;
//   a new request is accepted only after its last character is loaded; 3888 gives the longest
//   numeral, and zero or out-of-range requests give a single invalid character
// synchronous active-low reset clears control and r_valid; uses itr_pkg, itr_ctrl, itr_datapath
`timescale 1ns / 1ps

module integer_to_roman_encoder
    import itr_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [VALUE_W-1:0]  i_value,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [SYMBOL_W-1:0] o_symbol,
    output logic                o_last,
    output logic                o_invalid
);

    t_cmd    cmd;
    t_status status;

    itr_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_status (status),
        .o_cmd    (cmd),
        .o_stall  (o_stall)
    );

    itr_datapath u_datapath (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_value   (i_value),
        .i_stall   (i_stall),
        .i_cmd     (cmd),
        .o_status  (status),
        .o_valid   (o_valid),
        .o_symbol  (o_symbol),
        .o_last    (o_last),
        .o_invalid (o_invalid)
    );

    // an invalid result is a lone zero character
    a_invalid_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_invalid |-> o_last && (o_symbol == CH_NONE))
        else $error("invalid result not a single zero character");

    // a valid result carries a numeral letter
    a_letter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_invalid |-> (o_symbol == CH_I) || (o_symbol == CH_V) ||
            (o_symbol == CH_X) || (o_symbol == CH_L) || (o_symbol == CH_C) ||
            (o_symbol == CH_D) || (o_symbol == CH_M))
        else $error("result symbol is not a numeral letter");

    // an accepted request keeps the input stalled while it is worked on
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("input not stalled after accepting a request");

    // a new character is only loaded when the output register is free
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_symbol) && $stable(o_last))
        else $error("pending result overwritten");

endmodule

>>> verif/testbench.sv
// testbench: checks integer_to_roman_encoder against its own numeral predictor
// directed table of requests, then random ones under idling and back-pressure; uses itr_pkg
`timescale 1ns / 1ps

module testbench;
    import itr_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 300;
    localparam int DIR_ROWS    = 24;
    localparam string SPELL_PREDICT = "";
    localparam string SPELL_INVALID = "-";

    typedef struct packed {
        logic [SYMBOL_W-1:0] symbol;
        logic                last;
        logic                invalid;
    } t_numeral_char;

    typedef enum logic [1:0] {
        PH_RANDOM,
        PH_CALM,
        PH_HOLD
    } t_drive_phase;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_valid = 1'b0;
    logic [VALUE_W-1:0]  i_value = '0;
    logic                i_stall = 1'b0;
    logic                o_stall;
    logic                o_valid;
    logic [SYMBOL_W-1:0] o_symbol;
    logic                o_last;
    logic                o_invalid;

    t_numeral_char pending_chars[$];
    t_drive_phase  phase = PH_RANDOM;
    int            error_count = 0;
    int            cycle_count = 0;
    int            hold_count = 0;

    // directed requests; a spelled-out numeral is typed in where it is obvious
    logic [VALUE_W-1:0] dir_value [DIR_ROWS] = '{
        12'd0, 12'd4095, 12'd4000, 12'd1, 12'd3999, 12'd3888, 12'd4, 12'd9,
        12'd40, 12'd90, 12'd400, 12'd900, 12'd3000, 12'd5, 12'd10, 12'd500,
        12'd1000, 12'd8, 12'd2048, 12'd1365, 12'd2730, 12'd1001, 12'd49, 12'd2222
    };
    string dir_spelled [DIR_ROWS] = '{
        SPELL_INVALID, SPELL_INVALID, SPELL_INVALID, "I", "MMMCMXCIX",
        "MMMDCCCLXXXVIII", "IV", "IX", "XL", "XC", "CD", "CM", "MMM", "V", "X", "D",
        "M", "VIII", SPELL_PREDICT, SPELL_PREDICT, SPELL_PREDICT, SPELL_PREDICT,
        SPELL_PREDICT, SPELL_PREDICT
    };

    integer_to_roman_encoder u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_value  (i_value),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_symbol (o_symbol),
        .o_last   (o_last),
        .o_invalid(o_invalid)
    );

    always #5 i_clk = ~i_clk;

    // expected characters of one request, most significant digit first
    function automatic void predict_numeral(input logic [VALUE_W-1:0] v);
        logic [SYMBOL_W-1:0] chars [15];
        logic [SYMBOL_W-1:0] one, five, ten;
        int digit [4];
        int n;
        t_numeral_char c;
        n = 0;
        if (v == 0 || v > MAX_VALUE) begin
            c = '{symbol: CH_NONE, last: 1'b1, invalid: 1'b1};
            pending_chars.push_back(c);
            return;
        end
        digit[3] = v / 1000;
        digit[2] = (v / 100) % 10;
        digit[1] = (v / 10) % 10;
        digit[0] = v % 10;
        for (int p = 3; p >= 0; p--) begin
            case (p)
                0: begin one = CH_I; five = CH_V; ten = CH_X; end
                1: begin one = CH_X; five = CH_L; ten = CH_C; end
                2: begin one = CH_C; five = CH_D; ten = CH_M; end
                default: begin one = CH_M; five = CH_M; ten = CH_M; end
            endcase
            case (digit[p])
                1, 2, 3: begin
                    for (int i = 0; i < digit[p]; i++) begin
                        chars[n] = one;
                        n++;
                    end
                end
                4: begin
                    chars[n] = one;
                    chars[n + 1] = five;
                    n += 2;
                end
                5: begin
                    chars[n] = five;
                    n++;
                end
                6, 7, 8: begin
                    chars[n] = five;
                    n++;
                    for (int i = 5; i < digit[p]; i++) begin
                        chars[n] = one;
                        n++;
                    end
                end
                9: begin
                    chars[n] = one;
                    chars[n + 1] = ten;
                    n += 2;
                end
                default: ;
            endcase
        end
        for (int k = 0; k < n; k++) begin
            c = '{symbol: chars[k], last: (k == n - 1), invalid: 1'b0};
            pending_chars.push_back(c);
        end
    endfunction

    function automatic logic [VALUE_W-1:0] pick_value();
        int r;
        r = $urandom_range(99);
        if (r < 2) return '0;
        if (r < 8) return VALUE_W'($urandom_range(4000, 4095));
        if (r < 15) return VALUE_W'($urandom_range(0, 4095));
        // long runs built around 888
        if (r < 22) return VALUE_W'($urandom_range(0, 3) * 1000 + 888);
        return VALUE_W'($urandom_range(1, MAX_VALUE));
    endfunction

    // called at a clock edge; returns at the edge where the request is taken
    task automatic offer_value(input logic [VALUE_W-1:0] v);
        int gap;
        gap = 0;
        if (phase != PH_CALM && $urandom_range(99) < 23) gap = $urandom_range(1, 6);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_value <= v;
        do @(posedge i_clk); while (o_stall);
    endtask

    task automatic drain_results();
        while (pending_chars.size() != 0) @(posedge i_clk);
    endtask

    // receiver side: random stalls, a calm stretch and one long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (phase == PH_HOLD && hold_count < HOLD_CYCLES) begin
            i_stall <= 1'b1;
            hold_count <= hold_count + 1;
        end else if (phase == PH_CALM) begin
            i_stall <= 1'b0;
        end else begin
            i_stall <= ($urandom_range(99) < 23);
        end
    end

    always @(posedge i_clk) begin
        t_numeral_char exp_c;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_chars.size() == 0) begin
                $error("unexpected character: symbol %h last %b invalid %b",
                       o_symbol, o_last, o_invalid);
                error_count++;
            end else begin
                exp_c = pending_chars.pop_front();
                if (o_symbol !== exp_c.symbol) begin
                    $error("symbol: expected %h, got %h", exp_c.symbol, o_symbol);
                    error_count++;
                end
                if (o_last !== exp_c.last) begin
                    $error("last: expected %b, got %b", exp_c.last, o_last);
                    error_count++;
                end
                if (o_invalid !== exp_c.invalid) begin
                    $error("invalid: expected %b, got %b", exp_c.invalid, o_invalid);
                    error_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        t_numeral_char c;
        string spelled;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int row = 0; row < DIR_ROWS; row++) begin
            offer_value(dir_value[row]);
            spelled = dir_spelled[row];
            if (spelled == SPELL_INVALID) begin
                c = '{symbol: CH_NONE, last: 1'b1, invalid: 1'b1};
                pending_chars.push_back(c);
            end else if (spelled == SPELL_PREDICT) begin
                predict_numeral(dir_value[row]);
            end else begin
                for (int i = 0; i < spelled.len(); i++) begin
                    c = '{symbol: SYMBOL_W'(spelled[i]),
                          last: (i == spelled.len() - 1), invalid: 1'b0};
                    pending_chars.push_back(c);
                end
            end
        end

        // sender waits for every character before the hold-off
        i_valid <= 1'b0;
        drain_results();
        phase <= PH_HOLD;
        for (int n = 0; n < 25; n++) begin
            logic [VALUE_W-1:0] v;
            v = pick_value();
            offer_value(v);
            predict_numeral(v);
        end

        i_valid <= 1'b0;
        drain_results();
        phase <= PH_CALM;
        for (int n = 0; n < 40; n++) begin
            logic [VALUE_W-1:0] v;
            v = pick_value();
            offer_value(v);
            predict_numeral(v);
        end

        phase <= PH_RANDOM;
        for (int n = 0; n < 91; n++) begin
            logic [VALUE_W-1:0] v;
            v = pick_value();
            offer_value(v);
            predict_numeral(v);
        end
        i_valid <= 1'b0;

        drain_results();
        repeat (40) @(posedge i_clk);
        if (error_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
